@@ hdl/least_used_page_replacement_defines.svh @@
// Assertion macros for the least-used page replacement block
`ifndef LEAST_USED_PAGE_REPLACEMENT_DEFINES_SVH
`define LEAST_USED_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LUPR_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lupr assertion failed");

// next-cycle implication, checked outside reset
`define LUPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lupr assertion failed");

`endif

@@ hdl/lupr_pkg.sv @@
// Types and constants for the least-used page replacement block
`timescale 1ns / 1ps

package lupr_pkg;

	localparam int SLOTS      = 8;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int FILL_W     = $clog2(SLOTS + 1);
	localparam int PAGE_W     = 8;
	localparam int CNT_W      = 14;
	localparam int SLOT_OUT_W = 3;
	localparam int TOTAL_W    = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(9999);

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

endpackage

@@ hdl/least_used_page_replacement.sv @@
// Least-used page replacement table: top level with scan, update and slot memory
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  request  | page_id                                 | start, busy
//  result   | was_hit, was_fault, wrote_back,         | done (one-cycle strobe)
//           | slot_used, hit_total, fault_total,      |
//           | writeback_total                         |
//
// One request at a time: the slot memory has a single read port, so every slot
// is read in turn in ST_SCAN, ST_LAST drains the read data, ST_UPDATE writes the
// chosen slot back and registers the result, and busy holds until ST_IDLE is back.
// done rises as the block returns to idle; start may be taken in that cycle.
// Reset clears the fill count, totals and control; no clearing pass.
// The receiver cannot stall; busy alone holds the sender off.
`timescale 1ns / 1ps
`include "least_used_page_replacement_defines.svh"

module least_used_page_replacement
	import lupr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [PAGE_W-1:0]     page_id,
	output logic                  done,
	output logic                  was_hit,
	output logic                  was_fault,
	output logic                  wrote_back,
	output logic [SLOT_OUT_W-1:0] slot_used,
	output logic [TOTAL_W-1:0]    hit_total,
	output logic [TOTAL_W-1:0]    fault_total,
	output logic [TOTAL_W-1:0]    writeback_total
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_LAST   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   addr_q;
	logic [PAGE_W-1:0]   page_q;
	logic [FILL_W-1:0]   filled_q;

	entry_t              slot_mem_q [SLOTS];
	entry_t              rd_data_q;
	logic [SLOT_W-1:0]   tag_s1;
	logic                vld_s1;

	logic                hit_found_q;
	logic [SLOT_W-1:0]   hit_slot_q;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic [SLOT_W-1:0]   min_slot_q;
	logic [CNT_W-1:0]    min_cnt_q;

	logic                done_q;
	logic                was_hit_q;
	logic                wrote_back_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TOTAL_W-1:0]  hits_q;
	logic [TOTAL_W-1:0]  faults_q;
	logic [TOTAL_W-1:0]  wbs_q;

	logic                accept;
	logic                entry_filled;
	logic                table_full;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	entry_t              wr_data;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign entry_filled = (FILL_W'(tag_s1) < filled_q);
	assign table_full   = (filled_q == FILL_W'(SLOTS));

	always_comb begin
		wr_en        = (state_q == ST_UPDATE);
		wr_data.page = page_q;
		wr_data.cnt  = '0;
		priority if (hit_found_q) begin
			wr_addr     = hit_slot_q;
			wr_data.cnt = (hit_cnt_q < COUNT_MAX) ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
		end else if (!table_full) begin
			wr_addr = filled_q[SLOT_W-1:0];
		end else begin
			wr_addr = min_slot_q;
		end
	end

	// slot memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= slot_mem_q[addr_q];
		tag_s1    <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			vld_s1       <= 1'b0;
			filled_q     <= '0;
			hit_found_q  <= 1'b0;
			done_q       <= 1'b0;
			hits_q       <= '0;
			faults_q     <= '0;
			wbs_q        <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q      <= '0;
						hit_found_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + SLOT_W'(1);
					if (addr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					priority if (hit_found_q) begin
						hits_q <= hits_q + TOTAL_W'(1);
					end else if (!table_full) begin
						filled_q <= filled_q + FILL_W'(1);
						faults_q <= faults_q + TOTAL_W'(1);
					end else begin
						faults_q <= faults_q + TOTAL_W'(1);
						wbs_q    <= wbs_q + TOTAL_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vld_s1 && entry_filled && !hit_found_q && rd_data_q.page == page_q) begin
				hit_found_q <= 1'b1;
			end
		end
	end

	// payload: request page, scan results, result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_id;
		end
		if (vld_s1) begin
			if (entry_filled && !hit_found_q && rd_data_q.page == page_q) begin
				hit_slot_q <= tag_s1;
				hit_cnt_q  <= rd_data_q.cnt;
			end
			if (tag_s1 == '0 || rd_data_q.cnt < min_cnt_q) begin
				min_cnt_q  <= rd_data_q.cnt;
				min_slot_q <= tag_s1;
			end
		end
		if (state_q == ST_UPDATE) begin
			was_hit_q    <= hit_found_q;
			wrote_back_q <= !hit_found_q && table_full;
			slot_q       <= wr_addr;
		end
	end

	assign done            = done_q;
	assign was_hit         = was_hit_q;
	assign was_fault       = !was_hit_q;
	assign wrote_back      = wrote_back_q;
	assign slot_used       = SLOT_OUT_W'(slot_q);
	assign hit_total       = hits_q;
	assign fault_total     = faults_q;
	assign writeback_total = wbs_q;

	`LUPR_ASSERT_IMPLY(a_fill_bound, 1'b1, filled_q <= FILL_W'(SLOTS))
	`LUPR_ASSERT_IMPLY(a_wb_needs_full, done && wrote_back, table_full && was_fault)
	`LUPR_ASSERT_NEXT(a_accept_busy, accept, busy)
	`LUPR_ASSERT_NEXT(a_update_done, state_q == ST_UPDATE, done && !busy)
	`LUPR_ASSERT_IMPLY(a_done_idle, done, !busy || accept == 1'b0)

endmodule

@@ verif/least_used_page_replacement_test.sv @@
// Self-checking testbench for the least-used page replacement table
`timescale 1ns / 1ps

module least_used_page_replacement_test;
	import lupr_pkg::*;

	typedef struct {
		logic                  hit;
		logic                  fault;
		logic                  wb;
		logic [SLOT_OUT_W-1:0] slot;
		logic [TOTAL_W-1:0]    hits;
		logic [TOTAL_W-1:0]    faults;
		logic [TOTAL_W-1:0]    wbs;
	} page_outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [PAGE_W-1:0]     page_id = '0;
	logic                  busy;
	logic                  done;
	logic                  was_hit;
	logic                  was_fault;
	logic                  wrote_back;
	logic [SLOT_OUT_W-1:0] slot_used;
	logic [TOTAL_W-1:0]    hit_total;
	logic [TOTAL_W-1:0]    fault_total;
	logic [TOTAL_W-1:0]    writeback_total;

	// shadow copy of the table
	logic [PAGE_W-1:0]  shadow_page [SLOTS];
	logic [CNT_W-1:0]   shadow_cnt [SLOTS];
	int                 shadow_filled = 0;
	logic [TOTAL_W-1:0] shadow_hits = '0;
	logic [TOTAL_W-1:0] shadow_faults = '0;
	logic [TOTAL_W-1:0] shadow_wbs = '0;

	page_outcome_t     pending_outcomes [$];
	logic [PAGE_W-1:0] working_set [10];
	int                mismatches = 0;
	int                results_seen = 0;
	int                pages_sent = 0;

	least_used_page_replacement dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.page_id         (page_id),
		.done            (done),
		.was_hit         (was_hit),
		.was_fault       (was_fault),
		.wrote_back      (wrote_back),
		.slot_used       (slot_used),
		.hit_total       (hit_total),
		.fault_total     (fault_total),
		.writeback_total (writeback_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#12_000_000;
		$display("FAILURE");
		$finish;
	end

	// least-frequently-used lookup, hit / fill / evict
	task automatic lfu_reference(input logic [PAGE_W-1:0] page);
		page_outcome_t o;
		int            slot;
		int            best;
		bit            found;
		found = 1'b0;
		slot  = 0;
		o.hit = 1'b0;
		o.wb  = 1'b0;
		for (int i = 0; i < shadow_filled; i++) begin
			if (!found && shadow_page[i] == page) begin
				found = 1'b1;
				slot  = i;
			end
		end
		if (found) begin
			o.hit = 1'b1;
			shadow_hits++;
			if (shadow_cnt[slot] < COUNT_MAX)
				shadow_cnt[slot]++;
		end else if (shadow_filled < SLOTS) begin
			slot = shadow_filled;
			shadow_page[slot] = page;
			shadow_cnt[slot]  = '0;
			shadow_filled++;
			shadow_faults++;
		end else begin
			best = int'(COUNT_MAX) + 1;
			for (int i = 0; i < SLOTS; i++) begin
				if (int'(shadow_cnt[i]) < best) begin
					best = int'(shadow_cnt[i]);
					slot = i;
				end
			end
			shadow_page[slot] = page;
			shadow_cnt[slot]  = '0;
			shadow_faults++;
			shadow_wbs++;
			o.wb = 1'b1;
		end
		o.fault  = !o.hit;
		o.slot   = SLOT_OUT_W'(slot);
		o.hits   = shadow_hits;
		o.faults = shadow_faults;
		o.wbs    = shadow_wbs;
		pending_outcomes.push_back(o);
	endtask

	// call just after a rising edge; returns at the edge that takes the transfer
	task automatic send_page(input logic [PAGE_W-1:0] page);
		start   <= 1'b1;
		page_id <= page;
		do
			@(posedge clk);
		while (busy);
		lfu_reference(page);
		pages_sent++;
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
	endtask

	task automatic compare_field(input string name, input logic [TOTAL_W-1:0] want,
			input logic [TOTAL_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		page_outcome_t e;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, expected nothing, got slot %0d",
					$time, slot_used);
			end else begin
				e = pending_outcomes.pop_front();
				results_seen++;
				compare_field("was_hit", TOTAL_W'(e.hit), TOTAL_W'(was_hit));
				compare_field("was_fault", TOTAL_W'(e.fault), TOTAL_W'(was_fault));
				compare_field("wrote_back", TOTAL_W'(e.wb), TOTAL_W'(wrote_back));
				compare_field("slot_used", TOTAL_W'(e.slot), TOTAL_W'(slot_used));
				compare_field("hit_total", e.hits, hit_total);
				compare_field("fault_total", e.faults, fault_total);
				compare_field("writeback_total", e.wbs, writeback_total);
			end
		end
	end

	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(0, 6) == 0)
			return PAGE_W'($urandom);
		return working_set[$urandom_range(0, 9)];
	endfunction

	// empty table, fill of every slot, hits, evictions with ties
	task automatic test_fill_and_evict();
		logic [PAGE_W-1:0] fill [8];
		fill = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC};
		foreach (fill[i])
			send_page(fill[i]);
		send_page(8'h00);
		send_page(8'hFF);
		idle_burst();
		send_page(8'h00);
		send_page(8'h81);
		send_page(8'h7E);
		send_page(8'h81);
		send_page(8'h18);
		send_page(8'hFF);
		send_page(8'h7E);
	endtask

	task automatic test_drain_pause();
		send_page(8'h55);
		send_page(8'h24);
		drain_results();
		send_page(8'h24);
		send_page(8'hC3);
		drain_results();
	endtask

	task automatic test_random(input int count, input bit allow_idle);
		bit quiet;
		quiet = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				foreach (working_set[i])
					working_set[i] = PAGE_W'($urandom);
				quiet = ($urandom_range(0, 3) == 0);
			end
			if (allow_idle && !quiet && $urandom_range(0, 3) == 0)
				idle_burst();
			if (allow_idle && $urandom_range(0, 199) == 0)
				drain_results();
			send_page(pick_page());
		end
	endtask

	// hammer one resident page, then force evictions around it
	task automatic test_hot_page();
		logic [PAGE_W-1:0] hot;
		hot = shadow_page[0];
		repeat (40)
			send_page(hot);
		for (int n = 0; n < 12; n++)
			send_page(PAGE_W'($urandom));
		send_page(hot);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_and_evict();
		test_drain_pause();
		test_random(950, 1'b1);
		test_hot_page();
		test_random(250, 1'b0);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 6) @(posedge clk);
		$display("Sent %0d page references, checked %0d results: %0d hits, %0d write-backs,",
			pages_sent, results_seen, shadow_hits, shadow_wbs);
		$display("covering cold fill, eviction ties, a heavily used page and random idling.");
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lupr_pkg.sv
hdl/least_used_page_replacement.sv
verif/least_used_page_replacement_test.sv
